// ----- hw/rtl/dus_pkg.sv -----
// dus_pkg: shared types and constants for the dot-unstuffing stream filter
// used by the channel interfaces and dot_unstuff_stream_filter; no dependencies
`default_nettype none

package dus_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SLOTS   = 3;
  localparam int unsigned SLOT_W  = $clog2(SLOTS + 1);

  localparam logic [BYTE_W-1:0]  CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0]  CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0]  CH_LF     = 8'h0A;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_DOTS   = 2'd1,
    PH_TEXT   = 2'd2,
    PH_DOT_CR = 2'd3
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               is_data;
    logic               last;
    logic               done;
    logic [COUNT_W-1:0] total;
  } slot_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dus_in_if.sv -----
// dus_in_if: input beat channel (raw text byte and restart flag)
// depends on dus_pkg for field widths
`default_nettype none

interface dus_in_if;
  import dus_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              restart;

  modport source (output valid, output in_byte, output restart, input ready);
  modport sink (input valid, input in_byte, input restart, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dus_out_if.sv -----
// dus_out_if: result beat channel (emitted byte with status and running count)
// depends on dus_pkg for field widths
`default_nettype none

interface dus_out_if;
  import dus_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               byte_valid;
  logic               last_of_run;
  logic               done_res;
  logic [COUNT_W-1:0] total_bytes;

  modport source (output valid, output out_byte, output byte_valid, output last_of_run,
                  output done_res, output total_bytes, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input last_of_run,
                input done_res, input total_bytes, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dot_unstuff_stream_filter.sv -----
// dot_unstuff_stream_filter: smtp-style dot unstuffing of a byte stream
// depends on dus_pkg, dus_in_if and dus_out_if
//
//   channel     | dir | contents
//   raw         | in  | in_byte, restart
//   clean       | out | out_byte, byte_valid, last_of_run, done_res, total_bytes
//   cfg_wr_*    | in  | byte_limit register write
//
// One input beat is decoded per cycle, while raw.ready is high, into up to three
// result beats held in a three-entry output buffer. A new beat is taken when the
// buffer is empty or its last entry leaves in the same cycle, so single-result
// beats stream at one per cycle while clean.ready holds; an N-result beat leaves
// as N output beats first. Reset is synchronous and loads byte_limit and the
// transfer state; output stalls back up through the buffer to raw.ready.
`default_nettype none

module dot_unstuff_stream_filter (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [dus_pkg::COUNT_W-1:0] cfg_wr_data,
  dus_in_if.sink                 raw,
  dus_out_if.source              clean
);
  import dus_pkg::*;

  logic [COUNT_W-1:0] byte_limit;
  phase_t             phase;
  logic               several_dots;
  logic [COUNT_W-1:0] bytes_left;
  logic [COUNT_W-1:0] emitted_count;
  logic               finished;

  slot_t              slots [SLOTS];
  logic [SLOT_W-1:0]  fill;

  // effective state after an optional restart
  phase_t             e_phase;
  logic               e_sd;
  logic [COUNT_W-1:0] e_left;
  logic [COUNT_W-1:0] e_count;
  logic               e_fin;
  logic               active;

  phase_t             phase_next;
  logic               several_dots_next;
  logic [COUNT_W-1:0] bytes_left_next;
  logic [COUNT_W-1:0] emitted_count_next;
  logic               finished_next;
  logic               term;

  logic [BYTE_W-1:0]  emit [SLOTS];
  logic [SLOT_W-1:0]  n_emit;
  logic [SLOT_W-1:0]  n_res;
  logic [COUNT_W-1:0] cnt_at [SLOTS];
  logic [COUNT_W+1:0] sum_at [SLOTS];
  slot_t              new_slots [SLOTS];

  logic               accept;
  logic               pop;
  logic [BYTE_W-1:0]  ch;

  assign ch     = raw.in_byte;
  assign pop    = (fill != '0) && clean.ready;
  assign accept = raw.valid && raw.ready;

  assign raw.ready = (fill == '0) || ((fill == SLOT_W'(1)) && clean.ready);

  always_comb begin
    if (raw.restart) begin
      e_phase = PH_START;
      e_sd    = 1'b0;
      e_left  = byte_limit;
      e_count = '0;
      e_fin   = 1'b0;
    end else begin
      e_phase = phase;
      e_sd    = several_dots;
      e_left  = bytes_left;
      e_count = emitted_count;
      e_fin   = finished;
    end
    active = !e_fin && (e_left != '0);
  end

  // next line state
  always_comb begin
    phase_next        = e_phase;
    several_dots_next = e_sd;
    term              = 1'b0;
    if (active) begin
      case (e_phase)
        PH_START: begin
          if (ch == CH_DOT) begin
            phase_next        = PH_DOTS;
            several_dots_next = 1'b0;
          end else if (ch != CH_LF) begin
            phase_next = PH_TEXT;
          end
        end
        PH_DOTS: begin
          if (ch == CH_CR) begin
            phase_next = PH_DOT_CR;
          end else if (ch == CH_LF) begin
            if (!e_sd) term = 1'b1;
            else phase_next = PH_START;
          end else if (ch == CH_DOT) begin
            several_dots_next = 1'b1;
          end else begin
            phase_next = PH_TEXT;
          end
        end
        PH_TEXT: begin
          if (ch == CH_LF) phase_next = PH_START;
        end
        PH_DOT_CR: begin
          if (ch == CH_LF) begin
            if (!e_sd) term = 1'b1;
            else phase_next = PH_START;
          end else begin
            phase_next = PH_TEXT;
          end
        end
        default: phase_next = PH_START;
      endcase
    end
    bytes_left_next = active ? e_left - COUNT_W'(1) : e_left;
    if (e_fin) finished_next = 1'b1;
    else if (e_left == '0) finished_next = 1'b1;
    else finished_next = term || (e_left == COUNT_W'(1));
  end

  // emitted bytes
  always_comb begin
    n_emit = '0;
    for (int k = 0; k < SLOTS; k++) emit[k] = ch;
    if (active) begin
      case (e_phase)
        PH_START: begin
          if (ch != CH_DOT) n_emit = SLOT_W'(1);
        end
        PH_DOTS: begin
          if (ch == CH_LF) begin
            if (e_sd) n_emit = SLOT_W'(1);
          end else if (ch == CH_DOT) begin
            n_emit = SLOT_W'(1);
          end else if (ch != CH_CR) begin
            emit[0] = CH_DOT;
            n_emit  = SLOT_W'(2);
          end
        end
        PH_TEXT: n_emit = SLOT_W'(1);
        PH_DOT_CR: begin
          if (ch == CH_LF) begin
            if (e_sd) begin
              emit[0] = CH_CR;
              n_emit  = SLOT_W'(2);
            end
          end else begin
            emit[0] = CH_DOT;
            emit[1] = CH_CR;
            n_emit  = SLOT_W'(3);
          end
        end
        default: n_emit = '0;
      endcase
    end
  end

  // saturating running counts and result slots
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      sum_at[k] = {2'b00, e_count} + (COUNT_W + 2)'(k + 1);
      cnt_at[k] = (sum_at[k][COUNT_W+1:COUNT_W] != 2'b00) ? COUNT_MAX
                                                         : sum_at[k][COUNT_W-1:0];
    end
    if (n_emit == '0) emitted_count_next = e_count;
    else emitted_count_next = cnt_at[n_emit - SLOT_W'(1)];

    if (e_fin) n_res = '0;
    else if (n_emit != '0) n_res = n_emit;
    else n_res = finished_next ? SLOT_W'(1) : '0;

    for (int k = 0; k < SLOTS; k++) begin
      if (n_emit == '0) begin
        new_slots[k].data    = '0;
        new_slots[k].is_data = 1'b0;
        new_slots[k].last    = 1'b1;
        new_slots[k].total   = e_count;
      end else begin
        new_slots[k].data    = emit[k];
        new_slots[k].is_data = 1'b1;
        new_slots[k].last    = (SLOT_W'(k + 1) == n_emit);
        new_slots[k].total   = cnt_at[k];
      end
      new_slots[k].done = finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit <= COUNT_MAX;
    end else if (cfg_wr_en) begin
      byte_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      several_dots  <= 1'b0;
      bytes_left    <= COUNT_MAX;
      emitted_count <= '0;
      finished      <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      several_dots  <= several_dots_next;
      bytes_left    <= bytes_left_next;
      emitted_count <= emitted_count_next;
      finished      <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= n_res;
    end else if (pop) begin
      fill <= fill - SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < SLOTS; k++) slots[k] <= new_slots[k];
    end else if (pop) begin
      for (int k = 0; k < SLOTS - 1; k++) slots[k] <= slots[k + 1];
    end
  end

  assign clean.valid       = (fill != '0);
  assign clean.out_byte    = slots[0].data;
  assign clean.byte_valid  = slots[0].is_data;
  assign clean.last_of_run = slots[0].last;
  assign clean.done_res    = slots[0].done;
  assign clean.total_bytes = slots[0].total;

endmodule

`default_nettype wire
